/* rtl/core/grr_pkg.sv */
// grr_pkg: shared types and constants of the group reverse reorder core
// no dependencies; imported by every module of the core

package grr_pkg;

   localparam int CSR_W     = 5;
   localparam int GRP_CNT_W = 7;

   typedef struct packed {
      logic                 bank;
      logic [GRP_CNT_W-1:0] count;
      logic                 reverse;
      logic                 eos;
   } grr_cmd_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } grr_rel_type;

endpackage

/* rtl/core/grr_front.sv */
// grr_front: accepts words, writes them into the free bank, and queues a drain command
// per completed group or sequence end; depends on grr_pkg

module grr_front #(
   parameter int DATA_WIDTH = 32,
   parameter int MAX_GROUP  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [grr_pkg::CSR_W-1:0]        group_size,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [DATA_WIDTH-1:0]            req_value,
   input  logic                             req_eos,
   output logic                             wr_en,
   output logic [$clog2(2*MAX_GROUP)-1:0]   wr_addr,
   output logic [DATA_WIDTH-1:0]            wr_data,
   output logic                             cmd_push,
   output grr_pkg::grr_cmd_type             cmd,
   input  grr_pkg::grr_rel_type             rel
);
   import grr_pkg::*;

   localparam int CNT_W  = $clog2(MAX_GROUP + 1);
   localparam int ADDR_W = $clog2(2 * MAX_GROUP);

   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic                 bank_ff, bank_in;
   logic [1:0]           busy_ff, busy_in;
   logic [GRP_CNT_W-1:0] size_eff;
   logic [GRP_CNT_W-1:0] n_wide;
   logic                 accept;
   logic                 complete;

   always_comb begin
      if (group_size == '0) begin
         size_eff = GRP_CNT_W'(1);
      end else if (GRP_CNT_W'(group_size) > GRP_CNT_W'(MAX_GROUP)) begin
         size_eff = GRP_CNT_W'(MAX_GROUP);
      end else begin
         size_eff = GRP_CNT_W'(group_size);
      end
   end

   assign req_tready = !busy_ff[bank_ff];
   assign accept     = req_tvalid && req_tready;
   assign n_wide     = GRP_CNT_W'(fill_ff) + GRP_CNT_W'(1);
   assign complete   = n_wide >= size_eff;
   assign cmd_push   = accept && (complete || req_eos);

   assign wr_en   = accept;
   assign wr_addr = ADDR_W'(bank_ff) * ADDR_W'(MAX_GROUP) + ADDR_W'(fill_ff);
   assign wr_data = req_value;

   assign cmd.bank    = bank_ff;
   assign cmd.count   = n_wide;
   assign cmd.reverse = complete;
   assign cmd.eos     = req_eos;

   always_comb begin
      fill_in = fill_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (accept) begin
         if (cmd_push) begin
            fill_in          = '0;
            bank_in          = !bank_ff;
            busy_in[bank_ff] = 1'b1;
         end else begin
            fill_in = CNT_W'(n_wide);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bank_ff <= 1'b0;
         busy_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

/* rtl/core/grr_cmd_fifo.sv */
// grr_cmd_fifo: two-entry queue of drain commands between front and back
// depends on grr_pkg

module grr_cmd_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  grr_pkg::grr_cmd_type din,
   input  logic                 pop,
   output logic                 empty,
   output grr_pkg::grr_cmd_type head
);
   import grr_pkg::*;

   grr_cmd_type entry_ff [2];
   logic        wp_ff, wp_in;
   logic        rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign empty = cnt_ff == 2'd0;
   assign head  = entry_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wp_ff] <= din;
      end
   end

endmodule

/* rtl/core/grr_back.sv */
// grr_back: two-bank word memory and drain engine; reads each queued group in
// forward or reverse order into a two-entry output queue; depends on grr_pkg

module grr_back #(
   parameter int DATA_WIDTH = 32,
   parameter int MAX_GROUP  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [$clog2(2*MAX_GROUP)-1:0]   wr_addr,
   input  logic [DATA_WIDTH-1:0]            wr_data,
   input  logic                             cmd_empty,
   input  grr_pkg::grr_cmd_type             cmd_head,
   output logic                             cmd_pop,
   output grr_pkg::grr_rel_type             rel,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [DATA_WIDTH-1:0]            rsp_value,
   output logic                             rsp_last,
   output logic                             rsp_done
);
   import grr_pkg::*;

   localparam int ADDR_W = $clog2(2 * MAX_GROUP);

   logic [DATA_WIDTH-1:0] store_ff [2*MAX_GROUP];

   logic                  active_ff, active_in;
   grr_cmd_type           cur_ff, cur_in;
   logic [GRP_CNT_W-1:0]  idx_ff, idx_in;

   logic                  rd_v_ff, rd_v_in;
   logic                  rd_last_ff, rd_last_in;
   logic                  rd_done_ff, rd_done_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic [DATA_WIDTH-1:0] oq_data_ff [2];
   logic                  oq_last_ff [2];
   logic                  oq_done_ff [2];
   logic                  owp_ff, owp_in;
   logic                  orp_ff, orp_in;
   logic [1:0]            ocnt_ff, ocnt_in;

   logic                  pop_out;
   logic [2:0]            occ;
   logic                  issue;
   logic                  is_last;
   logic [GRP_CNT_W-1:0]  cnt_m1;
   logic [GRP_CNT_W-1:0]  rd_idx;
   logic [ADDR_W-1:0]     rd_addr;

   assign rsp_tvalid = ocnt_ff != 2'd0;
   assign rsp_value  = oq_data_ff[orp_ff];
   assign rsp_last   = oq_last_ff[orp_ff];
   assign rsp_done   = oq_done_ff[orp_ff];
   assign pop_out    = rsp_tvalid && rsp_tready;

   // slots taken once the read in flight lands
   assign occ     = {1'b0, ocnt_ff} + {2'b0, rd_v_ff} - {2'b0, pop_out};
   assign issue   = active_ff && (occ < 3'd2);
   assign cnt_m1  = cur_ff.count - GRP_CNT_W'(1);
   assign is_last = idx_ff == cnt_m1;
   assign rd_idx  = cur_ff.reverse ? (cnt_m1 - idx_ff) : idx_ff;
   assign rd_addr = ADDR_W'(cur_ff.bank) * ADDR_W'(MAX_GROUP) + ADDR_W'(rd_idx);

   assign rel.valid = issue && is_last;
   assign rel.bank  = cur_ff.bank;

   always_comb begin
      active_in  = active_ff;
      cur_in     = cur_ff;
      idx_in     = idx_ff;
      cmd_pop    = 1'b0;
      rd_v_in    = issue;
      rd_last_in = is_last;
      rd_done_in = is_last && cur_ff.eos;
      if (issue) begin
         if (is_last) begin
            idx_in    = '0;
            active_in = !cmd_empty;
            cmd_pop   = !cmd_empty;
            if (!cmd_empty) begin
               cur_in = cmd_head;
            end
         end else begin
            idx_in = idx_ff + GRP_CNT_W'(1);
         end
      end else if (!active_ff && !cmd_empty) begin
         active_in = 1'b1;
         cmd_pop   = 1'b1;
         cur_in    = cmd_head;
         idx_in    = '0;
      end
   end

   always_comb begin
      owp_in  = rd_v_ff ? !owp_ff : owp_ff;
      orp_in  = pop_out ? !orp_ff : orp_ff;
      ocnt_in = ocnt_ff + {1'b0, rd_v_ff} - {1'b0, pop_out};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
         rd_v_ff   <= 1'b0;
         owp_ff    <= 1'b0;
         orp_ff    <= 1'b0;
         ocnt_ff   <= 2'd0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         rd_v_ff   <= rd_v_in;
         owp_ff    <= owp_in;
         orp_ff    <= orp_in;
         ocnt_ff   <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      rd_last_ff <= rd_last_in;
      rd_done_ff <= rd_done_in;
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= store_ff[rd_addr];
      end
      if (rd_v_ff) begin
         oq_data_ff[owp_ff] <= rd_data_ff;
         oq_last_ff[owp_ff] <= rd_last_ff;
         oq_done_ff[owp_ff] <= rd_done_ff;
      end
   end

endmodule

/* rtl/core/group_reverse_reorder_core.sv */
// group_reverse_reorder_core: top level, reverses a word stream in groups of a
// configurable size; depends on grr_pkg, grr_front, grr_cmd_fifo, grr_back
//
// channel  | direction | tdata                        | tlast            | tuser
// ---------+-----------+------------------------------+------------------+--------------
// req_     | in        | value (DATA_WIDTH, signed)   | end_of_sequence  | -
// rsp_     | out       | value_out (DATA_WIDTH, sgnd) | last_of_run      | sequence_done
// csr_     | in        | csr_wr_data: group_size (5)  | -                | -
//
// words enter one per cycle while their memory bank is free; two banks alternate
// a group drains through the single memory read port
// a new group waits while both banks still hold undrained groups
// synchronous reset empties both banks and queues and sets group_size to 1
// rsp_tready low holds the output queue; the front keeps filling the free bank

module group_reverse_reorder_core #(
   parameter int DATA_WIDTH = 32,
   parameter int MAX_GROUP  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]     req_tdata,  // value
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((DATA_WIDTH+7)/8)*8-1:0]     rsp_tdata,  // value_out
   output logic                                rsp_tlast,
   output logic                                rsp_tuser,  // sequence_done
   input  logic                                csr_wr_en,
   input  logic [grr_pkg::CSR_W-1:0]           csr_wr_data
);
   import grr_pkg::*;

   localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int ADDR_W  = $clog2(2 * MAX_GROUP);

   logic [CSR_W-1:0]      group_size_ff;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  cmd_push;
   logic                  cmd_pop;
   logic                  cmd_empty;
   grr_cmd_type           cmd;
   grr_cmd_type           cmd_head;
   grr_rel_type           rel;
   logic [DATA_WIDTH-1:0] rsp_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= CSR_W'(1);
      end else if (csr_wr_en) begin
         group_size_ff <= csr_wr_data;
      end
   end

   grr_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .MAX_GROUP  (MAX_GROUP)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .group_size (group_size_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_value  (req_tdata[DATA_WIDTH-1:0]),
      .req_eos    (req_tlast),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .cmd_push   (cmd_push),
      .cmd        (cmd),
      .rel        (rel)
   );

   grr_cmd_fifo u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .head  (cmd_head)
   );

   grr_back #(
      .DATA_WIDTH (DATA_WIDTH),
      .MAX_GROUP  (MAX_GROUP)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .cmd_empty  (cmd_empty),
      .cmd_head   (cmd_head),
      .cmd_pop    (cmd_pop),
      .rel        (rel),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast),
      .rsp_done   (rsp_tuser)
   );

   assign rsp_tdata = TDATA_W'(rsp_value);

endmodule

/* rtl/core/grr_checker.sv */
// grr_checker: port-level checks of the group reverse reorder core over time
// sees the top-level ports only; bound to group_reverse_reorder_core below

module grr_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [((DATA_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tuser
);

   // a stalled transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // a stalled transaction keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast)
         && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // sequence end only closes a run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("sequence_done without last_of_run");

   // nothing offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind group_reverse_reorder_core grr_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_grr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

/* test/testbench.sv */
`timescale 1ns / 1ps

// testbench: self-checking test of group_reverse_reorder_core, a directed step list followed
// by random word sequences over many group sizes, with random idling on both streams
// depends on grr_pkg and the core RTL

module testbench;

   localparam int DATA_WIDTH   = 32;
   localparam int MAX_GROUP    = 16;
   localparam int BUS_W        = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int DRAIN_WAIT   = 48;
   localparam int RANDOM_WORDS = 400;
   localparam int QUIET_AFTER  = 340;
   localparam int STEP_COUNT   = 27;

   typedef enum logic [1:0] {STEP_CFG, STEP_WORD, STEP_CHECKED} step_kind_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic                  last_of_run;
      logic                  sequence_done;
   } reordered_word_type;

   typedef struct packed {
      step_kind_type             kind;
      logic [grr_pkg::CSR_W-1:0] group_size;
      logic [DATA_WIDTH-1:0]     value;
      logic                      eos;
      reordered_word_type        result;
   } directed_step_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [BUS_W-1:0]          req_tdata   = '0;
   logic                      req_tlast   = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [BUS_W-1:0]          rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tuser;
   logic                      csr_wr_en   = 1'b0;
   logic [grr_pkg::CSR_W-1:0] csr_wr_data = '0;

   // predictor state
   logic [DATA_WIDTH-1:0]     held_words [MAX_GROUP];
   int                        held_count     = 0;
   logic [grr_pkg::CSR_W-1:0] group_size_reg = 1;
   reordered_word_type        pending_words [$];
   reordered_word_type        oldest_word;
   directed_step_type         directed_steps [STEP_COUNT];

   int          mismatch_count = 0;
   int          words_sent     = 0;
   int          words_checked  = 0;
   int          settings_used  = 0;
   bit          idle_on        = 1'b1;
   int unsigned stall_left     = 0;

   group_reverse_reorder_core #(
      .DATA_WIDTH (DATA_WIDTH),
      .MAX_GROUP  (MAX_GROUP)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // value
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // value_out
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),   // sequence_done
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic directed_step_type make_step(input step_kind_type kind,
         input logic [grr_pkg::CSR_W-1:0] size, input logic [DATA_WIDTH-1:0] value,
         input logic eos, input logic [DATA_WIDTH-1:0] out_value, input logic out_last,
         input logic out_done);
      directed_step_type s;
      s.kind                 = kind;
      s.group_size           = size;
      s.value                = value;
      s.eos                  = eos;
      s.result.value         = out_value;
      s.result.last_of_run   = out_last;
      s.result.sequence_done = out_done;
      return s;
   endfunction

   // buffers one word and queues the words it releases
   function automatic void reorder_word(input logic [DATA_WIDTH-1:0] value, input logic eos);
      int size;
      int n;
      reordered_word_type r;
      size = (group_size_reg == 0) ? 1 : int'(group_size_reg);
      if (size > MAX_GROUP) size = MAX_GROUP;
      if (held_count >= MAX_GROUP) held_count = 0;
      held_words[held_count] = value;
      held_count++;
      n = held_count;
      if (n >= size || eos) begin
         for (int i = 0; i < n; i++) begin
            r.value         = (n >= size) ? held_words[n-1-i] : held_words[i];
            r.last_of_run   = (i == n - 1);
            r.sequence_done = (i == n - 1) && eos;
            pending_words.push_back(r);
         end
         held_count = 0;
      end
   endfunction

   task automatic send_word(input logic [DATA_WIDTH-1:0] value, input logic eos,
                            input bit checked, input reordered_word_type typed);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      reorder_word(value, eos);
      if (checked) pending_words[pending_words.size()-1] = typed;
      words_sent++;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic write_group_size(input logic [grr_pkg::CSR_W-1:0] size);
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      group_size_reg = size;
      settings_used++;
   endtask

   // result side: random stalls and checking
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected transaction: value_out %h", rsp_tdata[DATA_WIDTH-1:0]);
            mismatch_count++;
         end else begin
            oldest_word = pending_words.pop_front();
            if (rsp_tdata[DATA_WIDTH-1:0] !== oldest_word.value) begin
               $error("value_out: expected %h, got %h", oldest_word.value,
                      rsp_tdata[DATA_WIDTH-1:0]);
               mismatch_count++;
            end
            if (rsp_tlast !== oldest_word.last_of_run) begin
               $error("last_of_run: expected %b, got %b", oldest_word.last_of_run, rsp_tlast);
               mismatch_count++;
            end
            if (rsp_tuser !== oldest_word.sequence_done) begin
               $error("sequence_done: expected %b, got %b", oldest_word.sequence_done,
                      rsp_tuser);
               mismatch_count++;
            end
            words_checked++;
         end
      end
      if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 6);
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      directed_step_type     step;
      logic [DATA_WIDTH-1:0] value;
      int                    directed_words;
      int                    phase;
      int                    size;
      int                    eff_size;
      int                    phase_words;
      int                    seq_len;
      bit                    broken;

      directed_steps = '{
         // pass-through at reset size, field extremes
         make_step(STEP_CHECKED, 0, 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF, 1'b1, 1'b0),
         make_step(STEP_CHECKED, 0, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1, 1'b1),
         make_step(STEP_CHECKED, 0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0),
         make_step(STEP_CHECKED, 0, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b1),
         // zero size acts as one
         make_step(STEP_CFG,     0, '0, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_CHECKED, 0, 32'h1234_5678, 1'b1, 32'h1234_5678, 1'b1, 1'b1),
         make_step(STEP_CHECKED, 0, 32'h8765_4321, 1'b0, 32'h8765_4321, 1'b1, 1'b0),
         // full group reversed, then partial group flushed in order
         make_step(STEP_CFG,     3, '0, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'h0000_0001, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'h8000_0000, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'h7FFF_FFFF, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'hAAAA_AAAA, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'h5555_5555, 1'b1, '0, 1'b0, 1'b0),
         // full group closing the sequence
         make_step(STEP_CFG,     4, '0, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'h1111_1111, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'h2222_2222, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'h3333_3333, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'h4444_4444, 1'b1, '0, 1'b0, 1'b0),
         // size lowered below the words already held
         make_step(STEP_CFG,     8, '0, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'hDEAD_BEEF, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'h0000_0000, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_CFG,     2, '0, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'hC0FF_EE00, 1'b0, '0, 1'b0, 1'b0),
         // size above the buffer depth
         make_step(STEP_CFG,     17, '0, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'h0F0F_0F0F, 1'b0, '0, 1'b0, 1'b0),
         make_step(STEP_WORD,    0, 32'hF0F0_F0F0, 1'b1, '0, 1'b0, 1'b0)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         step = directed_steps[i];
         if (step.kind == STEP_CFG) begin
            write_group_size(step.group_size);
         end else begin
            send_word(step.value, step.eos, step.kind == STEP_CHECKED, step.result);
         end
      end
      directed_words = words_sent;

      phase = 0;
      while (words_sent - directed_words < RANDOM_WORDS) begin
         case (phase)
            0: size = 31;
            1: size = 16;
            2: size = 0;
            3: size = 1;
            4: size = 17;
            5: size = 2;
            default: begin
               size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
            end
         endcase
         write_group_size(size[grr_pkg::CSR_W-1:0]);
         idle_on  = (words_sent - directed_words < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
         eff_size = (size == 0) ? 1 : (size > MAX_GROUP) ? MAX_GROUP : size;
         phase_words = 0;
         while (phase_words < 30) begin
            // mostly whole sequences; a few with stray or missing end flags
            broken  = ($urandom_range(0, 5) == 0);
            seq_len = broken ? $urandom_range(1, 2 * eff_size)
                             : eff_size * $urandom_range(1, 3) + $urandom_range(0, eff_size - 1);
            for (int k = 1; k <= seq_len; k++) begin
               case ($urandom_range(0, 9))
                  0:       value = {1'b0, {(DATA_WIDTH-1){1'b1}}};
                  1:       value = {1'b1, {(DATA_WIDTH-1){1'b0}}};
                  2:       value = '1;
                  3:       value = '0;
                  default: value = $urandom();
               endcase
               if (words_sent - directed_words >= QUIET_AFTER) idle_on = 1'b0;
               send_word(value, broken ? ($urandom_range(0, 3) == 0) : (k == seq_len),
                         1'b0, '0);
            end
            phase_words += seq_len;
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Sent %0d words under %0d group size writes (sizes 0 to 31)",
               words_sent, settings_used);
      $display("Checked %0d reordered words field by field", words_checked);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d transactions still expected", pending_words.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
